>>> src/csrc_pkg.sv
// shared types and constants for the can stream receive checker
package csrc_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int COUNT_W      = 9;
  localparam int TICK_W       = 24;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 64;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_STREAM_ID      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_BYTES = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ERROR_PATTERN  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ERROR_LENGTH   = 3'd4;

  // opcodes of an input item
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // status codes reported on the result channel
  localparam logic [2:0] STATUS_IDLE      = 3'd0;
  localparam logic [2:0] STATUS_RECEIVING = 3'd1;
  localparam logic [2:0] STATUS_AWAIT_ACK = 3'd2;
  localparam logic [2:0] STATUS_SUCCESS   = 3'd3;
  localparam logic [2:0] STATUS_ERROR     = 3'd4;
  localparam logic [2:0] STATUS_TIMEOUT   = 3'd5;
  localparam logic [2:0] STATUS_WRONG_ACK = 3'd6;

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_RECEIVING = 7'b0000010,
    PH_AWAIT_ACK = 7'b0000100,
    PH_SUCCESS   = 7'b0001000,
    PH_ERROR     = 7'b0010000,
    PH_TIMEOUT   = 7'b0100000,
    PH_WRONG_ACK = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        send_open;
    logic        write_valid;
    logic [7:0]  write_offset;
    logic [3:0]  write_count;
    logic [63:0] write_data;
  } out_item_t;

  typedef struct packed {
    logic [15:0]       stream_id;
    logic [COUNT_W-1:0] expected_bytes;
    logic [TICK_W-1:0] timeout_ticks;
    logic [63:0]       error_pattern;
    logic [2:0]        error_length;
  } cfg_t;

endpackage

>>> src/csrc_core.sv
// transfer state and single-pass step logic of the stream receive checker
module csrc_core (
  input  logic                clk,
  input  logic                rst,
  input  csrc_pkg::cfg_t      cfg,
  input  logic                step,
  input  csrc_pkg::in_item_t  item,
  output csrc_pkg::out_item_t res
);

  csrc_pkg::phase_t                 phase, phase_next;
  logic [csrc_pkg::COUNT_W-1:0]     received_count, received_count_next;
  logic [7:0]                       running_xor, running_xor_next;
  logic [csrc_pkg::TICK_W-1:0]      elapsed_ticks, elapsed_ticks_next;

  logic [csrc_pkg::COUNT_W-1:0]     eff_expected;
  logic [csrc_pkg::COUNT_W-1:0]     remaining;
  logic [csrc_pkg::COUNT_W-1:0]     count_sum;
  logic [3:0]                       flen;
  logic [3:0]                       take;
  logic                             id_match;
  logic                             err_match;
  logic [7:0]                       term_byte;
  logic [63:0]                      kept_data;
  logic [7:0]                       frame_xor;
  logic [csrc_pkg::TICK_W-1:0]      ticks_inc;

  always_comb begin
    eff_expected = (cfg.expected_bytes > csrc_pkg::COUNT_W'(csrc_pkg::BUFFER_DEPTH)) ?
                   csrc_pkg::COUNT_W'(csrc_pkg::BUFFER_DEPTH) : cfg.expected_bytes;
    flen      = (item.frame_length > 4'd8) ? 4'd8 : item.frame_length;
    id_match  = (item.frame_id == cfg.stream_id);
    remaining = (received_count < eff_expected) ? (eff_expected - received_count) : '0;
    take      = (remaining < csrc_pkg::COUNT_W'(flen)) ? remaining[3:0] : flen;

    // error response: leading bytes equal the pattern, then a zero byte
    err_match = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if ((3'(i) < cfg.error_length) &&
          (item.frame_data[i*8 +: 8] != cfg.error_pattern[i*8 +: 8])) begin
        err_match = 1'b0;
      end
    end
    term_byte = item.frame_data[cfg.error_length*8 +: 8];
    if (term_byte != 8'd0) begin
      err_match = 1'b0;
    end

    // keep only the clamped bytes and fold them into the xor
    kept_data = '0;
    frame_xor = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < take) begin
        kept_data[i*8 +: 8] = item.frame_data[i*8 +: 8];
      end
      frame_xor = frame_xor ^ kept_data[i*8 +: 8];
    end

    count_sum = received_count + csrc_pkg::COUNT_W'(take);
    ticks_inc = (elapsed_ticks == {csrc_pkg::TICK_W{1'b1}}) ?
                elapsed_ticks : elapsed_ticks + 1'b1;
  end

  always_comb begin
    phase_next          = phase;
    received_count_next = received_count;
    running_xor_next    = running_xor;
    elapsed_ticks_next  = elapsed_ticks;
    res.send_open       = 1'b0;
    res.write_valid     = 1'b0;
    res.write_offset    = '0;
    res.write_count     = '0;
    res.write_data      = '0;

    if (item.opcode == csrc_pkg::OP_START) begin
      received_count_next = '0;
      running_xor_next    = '0;
      elapsed_ticks_next  = '0;
      res.send_open       = 1'b1;
      phase_next = (eff_expected == '0) ? csrc_pkg::PH_AWAIT_ACK : csrc_pkg::PH_RECEIVING;
    end else if ((item.opcode == csrc_pkg::OP_FRAME) && id_match) begin
      if (phase == csrc_pkg::PH_RECEIVING) begin
        if (err_match) begin
          phase_next = csrc_pkg::PH_ERROR;
        end else begin
          running_xor_next    = running_xor ^ frame_xor;
          received_count_next = count_sum;
          if (take != 4'd0) begin
            res.write_valid  = 1'b1;
            res.write_offset = received_count[7:0];
            res.write_count  = take;
            res.write_data   = kept_data;
          end
          if (count_sum >= eff_expected) begin
            phase_next = csrc_pkg::PH_AWAIT_ACK;
          end
        end
      end else if ((phase == csrc_pkg::PH_AWAIT_ACK) && (flen == 4'd1)) begin
        phase_next = (item.frame_data[7:0] == running_xor) ?
                     csrc_pkg::PH_SUCCESS : csrc_pkg::PH_WRONG_ACK;
      end
    end else if ((item.opcode == csrc_pkg::OP_TICK) &&
                 ((phase == csrc_pkg::PH_RECEIVING) || (phase == csrc_pkg::PH_AWAIT_ACK))) begin
      elapsed_ticks_next = ticks_inc;
      if (ticks_inc >= cfg.timeout_ticks) begin
        phase_next = csrc_pkg::PH_TIMEOUT;
      end
    end

    case (phase_next)
      csrc_pkg::PH_IDLE:      res.status = csrc_pkg::STATUS_IDLE;
      csrc_pkg::PH_RECEIVING: res.status = csrc_pkg::STATUS_RECEIVING;
      csrc_pkg::PH_AWAIT_ACK: res.status = csrc_pkg::STATUS_AWAIT_ACK;
      csrc_pkg::PH_SUCCESS:   res.status = csrc_pkg::STATUS_SUCCESS;
      csrc_pkg::PH_ERROR:     res.status = csrc_pkg::STATUS_ERROR;
      csrc_pkg::PH_TIMEOUT:   res.status = csrc_pkg::STATUS_TIMEOUT;
      csrc_pkg::PH_WRONG_ACK: res.status = csrc_pkg::STATUS_WRONG_ACK;
      default:                res.status = csrc_pkg::STATUS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= csrc_pkg::PH_IDLE;
      received_count <= '0;
      running_xor    <= '0;
      elapsed_ticks  <= '0;
    end else if (step) begin
      phase          <= phase_next;
      received_count <= received_count_next;
      running_xor    <= running_xor_next;
      elapsed_ticks  <= elapsed_ticks_next;
    end
  end

endmodule

>>> src/can_stream_receive_checker_unit.sv
// top level of the can stream receive checker: item/result channels and registers
//
// receiving side of a can stream transfer. each input item (start, received
// frame or timer tick) gives exactly one result: the status after the item,
// an open-command request on start, and for stream frames a buffer write of
// the payload bytes clamped at the expected length. a frame on the stream id
// that matches the configured error response ends the transfer with error;
// once all bytes are in, a one-byte frame is checked against the running xor
// of the payload. one item is taken every clock cycle unless the input
// stalls; the item is held in the input register while the step logic works
// on it, and its result is written to the result register at the same edge
// as the transfer state is updated. while the result side
// stalls with the result register full, the input register takes one more
// item and then the input stalls. registers are written through a plain write
// port and should only be changed while no item is in flight.
module can_stream_receive_checker_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // input items
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  csrc_pkg::in_item_t                   item,
  // results
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output csrc_pkg::out_item_t                  result,
  // register writes
  input  logic                                 cfg_write,
  input  logic [csrc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [csrc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  csrc_pkg::cfg_t       cfg;
  csrc_pkg::in_item_t   held_item;
  logic                 held_valid;
  logic                 advance;
  logic                 item_take;
  csrc_pkg::out_item_t  step_res;

  // the held item moves on when the result register is empty or being drained
  assign advance    = held_valid && (!result_valid || !result_stall);
  assign item_stall = held_valid && !advance;
  assign item_take  = item_valid && !item_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      held_item <= item;
    end
  end

  // transfer state and step logic
  csrc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (advance),
    .item (held_item),
    .res  (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_res;
    end
  end

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stream_id      <= '0;
      cfg.expected_bytes <= '0;
      cfg.timeout_ticks  <= csrc_pkg::TICK_W'(1000);
      cfg.error_pattern  <= '0;
      cfg.error_length   <= 3'd5;
    end else if (cfg_write) begin
      case (cfg_index)
        csrc_pkg::REG_STREAM_ID:      cfg.stream_id      <= cfg_data[15:0];
        csrc_pkg::REG_EXPECTED_BYTES: cfg.expected_bytes <= cfg_data[csrc_pkg::COUNT_W-1:0];
        csrc_pkg::REG_TIMEOUT_TICKS:  cfg.timeout_ticks  <= cfg_data[csrc_pkg::TICK_W-1:0];
        csrc_pkg::REG_ERROR_PATTERN:  cfg.error_pattern  <= cfg_data;
        csrc_pkg::REG_ERROR_LENGTH:   cfg.error_length   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

endmodule
